[src/ray_box_nearest_hit_top_assert.svh]
// Assertion helpers shared by the ray/box hit pipeline.
`ifndef RAY_BOX_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_BOX_NEAREST_HIT_TOP_ASSERT_SVH

// condition holds at every rising clock edge outside reset
`define RBNH_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("rbnh assertion failed");

// consequent holds in the same cycle as the antecedent
`define RBNH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rbnh implication failed");

`endif

[src/rbnh_pkg.sv]
package rbnh_pkg;

	// parameter defaults
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// fixed widths
	localparam int ANGLE_W  = 16;
	localparam int DIR_W    = 16;
	localparam int DIR_MAX  = 32767;
	localparam int LIMIT_W  = 63;
	localparam int DIST_W   = 64;
	localparam int CORDIC_W = 33;

	// CORDIC gain-compensated start, Q2.30
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = 33'sd652032874;
	localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 33'sh040000000;

	// atan(2^-i) in units of 2^32 per turn
	localparam logic [31:0] ATAN_TURNS [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	// divider: 32 quotient bits, 4 per stage
	localparam int QUOT_W          = 32;
	localparam int REM_W           = 16;
	localparam int DIV_BITS_STAGE  = 4;
	localparam int DIV_STAGES      = QUOT_W / DIV_BITS_STAGE;

	// edge lane: product, compare, divide setup, divide, offset, square, sum
	localparam int EDGE_LAT   = 6 + DIV_STAGES;
	localparam int CORDIC_PAD = 2;

	// hit point width: origin plus offset
	function automatic int pt_width(input int w);
		return ((w + 2 > 34) ? w + 2 : 34) + 1;
	endfunction

	// 1e7 scaled to Q32.32 style, saturated
	function automatic logic [LIMIT_W-1:0] reset_limit(input int frac);
		logic [63:0] v;
		v = 64'd10000000;
		if (2 * frac <= 39) begin
			v = v << (2 * frac);
			return v[LIMIT_W-1:0];
		end
		return '1;
	endfunction

	// Q2.30 to Q1.15, round half up, symmetric clamp
	function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] r;
		r = ((CORDIC_W+1)'(v) + (CORDIC_W+1)'(16384)) >>> 15;
		if (r > (CORDIC_W+1)'(DIR_MAX))
			return DIR_W'(DIR_MAX);
		if (r < -((CORDIC_W+1)'(DIR_MAX)))
			return -(DIR_W'(DIR_MAX));
		return DIR_W'(r);
	endfunction

endpackage

[src/rbnh_cordic.sv]
module rbnh_cordic #(
	parameter int STEPS = rbnh_pkg::CORDIC_STEPS_DEF,
	parameter int TAG_W = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic [rbnh_pkg::ANGLE_W-1:0]            angle,
	input  logic [TAG_W-1:0]                        tag_in,
	output logic                                    out_valid,
	output logic signed [rbnh_pkg::DIR_W-1:0]       dir_x,
	output logic signed [rbnh_pkg::DIR_W-1:0]       dir_y,
	output logic [TAG_W-1:0]                        tag_out
);
	import rbnh_pkg::*;

	logic                       v_s [STEPS+1];
	logic signed [CORDIC_W-1:0] x_s [STEPS+1];
	logic signed [CORDIC_W-1:0] y_s [STEPS+1];
	logic signed [CORDIC_W-1:0] z_s [STEPS+1];
	logic [1:0]                 q_s [STEPS+1];
	logic [TAG_W-1:0]           t_s [STEPS+1];

	logic signed [CORDIC_W-1:0] z_c;
	logic [1:0]                 q_c;
	logic signed [DIR_W-1:0]    cc, ss;

	// quadrant split, residue folded into [-1/8, 1/8) turn
	always_comb begin
		z_c = signed'(CORDIC_W'({angle[13:0], 16'h0000}));
		q_c = angle[15:14];
		if (angle[13]) begin
			z_c = z_c - QUARTER_TURN;
			q_c = q_c + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_K;
		y_s[0] <= '0;
		z_s[0] <= z_c;
		q_s[0] <= q_c;
		t_s[0] <= tag_in;
	end

	// one rotation per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic signed [CORDIC_W-1:0] ATAN_K = CORDIC_W'(ATAN_TURNS[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (z_s[k] >= 0) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - ATAN_K;
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + ATAN_K;
			end
			q_s[k+1] <= q_s[k];
			t_s[k+1] <= t_s[k];
		end
	end

	assign cc = sat_dir(x_s[STEPS]);
	assign ss = sat_dir(y_s[STEPS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[STEPS];
		end
	end

	// quadrant rotation
	always_ff @(posedge clk) begin
		unique case (q_s[STEPS])
			2'd0: begin
				dir_x <= cc;
				dir_y <= ss;
			end
			2'd1: begin
				dir_x <= -ss;
				dir_y <= cc;
			end
			2'd2: begin
				dir_x <= -cc;
				dir_y <= -ss;
			end
			default: begin
				dir_x <= ss;
				dir_y <= -cc;
			end
		endcase
		tag_out <= t_s[STEPS];
	end

endmodule

[src/rbnh_edge.sv]
module rbnh_edge #(
	parameter int COORD_WIDTH = rbnh_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                in_valid,
	input  logic signed [COORD_WIDTH+1:0]                       rel,
	input  logic signed [COORD_WIDTH+1:0]                       lo,
	input  logic signed [COORD_WIDTH+1:0]                       hi,
	input  logic signed [rbnh_pkg::DIR_W-1:0]                   along,
	input  logic signed [rbnh_pkg::DIR_W-1:0]                   across,
	input  logic                                                swap,
	input  logic signed [COORD_WIDTH-1:0]                       org_x,
	input  logic signed [COORD_WIDTH-1:0]                       org_y,
	output logic                                                out_valid,
	output logic [rbnh_pkg::DIST_W-1:0]                         dist_sq,
	output logic signed [rbnh_pkg::pt_width(COORD_WIDTH)-1:0]   pt_x,
	output logic signed [rbnh_pkg::pt_width(COORD_WIDTH)-1:0]   pt_y
);
	import rbnh_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int RW   = W + 2;
	localparam int PW   = RW + DIR_W;
	localparam int MW   = PW - 1;
	localparam int PHW  = MW - QUOT_W;
	localparam int CMPW = (PHW > DIR_W) ? PHW : DIR_W;
	localparam int PT_W = pt_width(W);
	localparam int OW   = PT_W - 1;

	typedef struct packed {
		logic                 ok;
		logic                 neg;
		logic                 swap;
		logic signed [RW-1:0] rel;
		logic signed [W-1:0]  org_x;
		logic signed [W-1:0]  org_y;
		logic [DIR_W-1:0]     ad;
	} side_t;

	// stage 1: cross products
	logic                 v_s1;
	logic signed [PW-1:0] p_s1, plo_s1, phi_s1;
	side_t                sd_s1;
	logic [DIR_W-1:0]     ad_c;
	logic signed [DIR_W:0] ads_c;
	side_t                sd_c1;

	always_comb begin
		ad_c        = along[DIR_W-1] ? DIR_W'(-along) : DIR_W'(along);
		ads_c       = signed'({1'b0, ad_c});
		sd_c1.ok    = (along != '0) && (rel != '0) && (rel[RW-1] == along[DIR_W-1]);
		sd_c1.neg   = along[DIR_W-1];
		sd_c1.swap  = swap;
		sd_c1.rel   = rel;
		sd_c1.org_x = org_x;
		sd_c1.org_y = org_y;
		sd_c1.ad    = ad_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= PW'(rel) * PW'(across);
		plo_s1 <= PW'(lo) * PW'(ads_c);
		phi_s1 <= PW'(hi) * PW'(ads_c);
		sd_s1  <= sd_c1;
	end

	// stage 2: orient by the normal direction, test strictly inside the edge
	logic                 v_s2;
	logic [MW-1:0]        pm_s2;
	side_t                sd_s2;
	logic signed [PW-1:0] p_c;
	side_t                sd_c2;
	logic [MW-1:0]        pm_c;

	always_comb begin
		p_c       = sd_s1.neg ? -p_s1 : p_s1;
		sd_c2     = sd_s1;
		sd_c2.ok  = sd_s1.ok && (plo_s1 < p_c) && (p_c < phi_s1);
		sd_c2.neg = p_c[PW-1];
		pm_c      = p_c[PW-1] ? MW'(-p_c) : MW'(p_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pm_s2 <= pm_c;
		sd_s2 <= sd_c2;
	end

	// stage 3: quotient range check, divider setup
	logic              v_d  [DIV_STAGES+1];
	logic [REM_W-1:0]  rem_d[DIV_STAGES+1];
	logic [QUOT_W-1:0] dl_d [DIV_STAGES+1];
	side_t             sd_d [DIV_STAGES+1];
	logic [PHW-1:0]    pm_hi;
	logic              ovf;
	side_t             sd_c3;

	always_comb begin
		pm_hi    = pm_s2[MW-1:QUOT_W];
		ovf      = CMPW'(pm_hi) >= CMPW'(sd_s2.ad);
		sd_c3    = sd_s2;
		sd_c3.ok = sd_s2.ok && !ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else begin
			v_d[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rem_d[0] <= REM_W'(pm_hi);
		dl_d[0]  <= pm_s2[QUOT_W-1:0];
		sd_d[0]  <= sd_c3;
	end

	// restoring divide by |along|, quotient shifts into the dividend register
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [REM_W-1:0]  rem_n;
		logic [QUOT_W-1:0] dl_n;

		always_comb begin : div_steps
			logic [REM_W:0] t;
			logic [REM_W:0] dv;
			rem_n = rem_d[k];
			dl_n  = dl_d[k];
			dv    = {1'b0, sd_d[k].ad};
			for (int j = 0; j < DIV_BITS_STAGE; j++) begin
				t    = {rem_n, dl_n[QUOT_W-1]};
				dl_n = {dl_n[QUOT_W-2:0], 1'b0};
				if (t >= dv) begin
					rem_n   = REM_W'(t - dv);
					dl_n[0] = 1'b1;
				end else begin
					rem_n = t[REM_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_d[k+1] <= rem_n;
			dl_d[k+1]  <= dl_n;
			sd_d[k+1]  <= sd_d[k];
		end
	end

	// stage 4: signed offset, place on the right axis
	logic                 v_s4, ok_s4;
	logic signed [OW-1:0] ox_s4, oy_s4;
	logic signed [W-1:0]  orgx_s4, orgy_s4;
	side_t                sd_f;
	logic signed [QUOT_W:0] q_c, off_c;

	always_comb begin
		sd_f  = sd_d[DIV_STAGES];
		q_c   = signed'({1'b0, dl_d[DIV_STAGES]});
		off_c = sd_f.neg ? -q_c : q_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_d[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		ok_s4   <= sd_f.ok;
		ox_s4   <= sd_f.swap ? OW'(off_c) : OW'(sd_f.rel);
		oy_s4   <= sd_f.swap ? OW'(sd_f.rel) : OW'(off_c);
		orgx_s4 <= sd_f.org_x;
		orgy_s4 <= sd_f.org_y;
	end

	// stage 5: squares, hit point
	logic                   v_s5, ok_s5;
	logic [DIST_W-1:0]      sqx_s5, sqy_s5;
	logic signed [PT_W-1:0] ptx_s5, pty_s5;
	logic [OW-1:0]          mx, my;
	logic                   satx, saty;

	always_comb begin
		mx   = ox_s4[OW-1] ? OW'(-ox_s4) : OW'(ox_s4);
		my   = oy_s4[OW-1] ? OW'(-oy_s4) : OW'(oy_s4);
		satx = |mx[OW-1:32];
		saty = |my[OW-1:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ok_s5  <= ok_s4 && !satx && !saty;
		sqx_s5 <= DIST_W'(mx[31:0]) * DIST_W'(mx[31:0]);
		sqy_s5 <= DIST_W'(my[31:0]) * DIST_W'(my[31:0]);
		ptx_s5 <= PT_W'(orgx_s4) + PT_W'(ox_s4);
		pty_s5 <= PT_W'(orgy_s4) + PT_W'(oy_s4);
	end

	// stage 6: distance, saturated when out of range or no hit
	logic [DIST_W:0] sum_c;

	assign sum_c = (DIST_W+1)'(sqx_s5) + (DIST_W+1)'(sqy_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		dist_sq <= (!ok_s5 || sum_c[DIST_W]) ? '1 : sum_c[DIST_W-1:0];
		pt_x    <= ptx_s5;
		pt_y    <= pty_s5;
	end

endmodule

[src/ray_box_nearest_hit_top.sv]
// Start to done: capture, CORDIC, edge lanes, pairwise and final compares, result register.
// Throughput: one beat per cycle while not busy; CORDIC and edge dividers are fully pipelined.
// Each result is held on hit/hit_x/hit_y for the single cycle that done is high.
// Reset: asynchronous; clears the pipeline, loads the default distance limit,
// and holds busy high until the first clock edge after release.
`include "ray_box_nearest_hit_top_assert.svh"

module ray_box_nearest_hit_top #(
	parameter int COORD_WIDTH  = rbnh_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS    = rbnh_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = rbnh_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_WIDTH-1:0]       ray_start_x,
	input  logic signed [COORD_WIDTH-1:0]       ray_start_y,
	input  logic [rbnh_pkg::ANGLE_W-1:0]        ray_angle,
	input  logic signed [COORD_WIDTH-1:0]       box_center_x,
	input  logic signed [COORD_WIDTH-1:0]       box_center_y,
	input  logic [COORD_WIDTH-2:0]              box_half_w,
	input  logic [COORD_WIDTH-2:0]              box_half_h,
	input  logic                                cfg_we,
	input  logic [rbnh_pkg::LIMIT_W-1:0]        cfg_wdata,
	output logic                                done,
	output logic                                hit,
	output logic signed [COORD_WIDTH-1:0]       hit_x,
	output logic signed [COORD_WIDTH-1:0]       hit_y
);
	import rbnh_pkg::*;

	localparam int W       = COORD_WIDTH;
	localparam int RW      = W + 2;
	localparam int PT_W    = pt_width(W);
	localparam int TOP_LAT = 1 + CORDIC_STEPS + CORDIC_PAD + EDGE_LAT + 3;

	typedef struct packed {
		logic signed [W-1:0]  px;
		logic signed [W-1:0]  py;
		logic signed [RW-1:0] xr;
		logic signed [RW-1:0] xl;
		logic signed [RW-1:0] yt;
		logic signed [RW-1:0] yb;
	} geo_t;

	localparam int TAG_W = $bits(geo_t);

	function automatic logic [W-1:0] clamp_coord(input logic [PT_W-1:0] v);
		if (&v[PT_W-1:W-1] || !(|v[PT_W-1:W-1]))
			return v[W-1:0];
		return v[PT_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	logic accept;
	logic busy_q;
	logic [LIMIT_W-1:0] lim_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			lim_q  <= reset_limit(FRAC_BITS);
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
		end
	end

	// stage 1: capture, edge lines relative to the ray start
	logic               v_s1;
	logic [ANGLE_W-1:0] ang_s1;
	geo_t               geo_s1;
	geo_t               geo_c;

	always_comb begin
		geo_c.px = ray_start_x;
		geo_c.py = ray_start_y;
		geo_c.xr = RW'(box_center_x) + RW'({1'b0, box_half_w}) - RW'(ray_start_x);
		geo_c.xl = RW'(box_center_x) - RW'({1'b0, box_half_w}) - RW'(ray_start_x);
		geo_c.yt = RW'(box_center_y) + RW'({1'b0, box_half_h}) - RW'(ray_start_y);
		geo_c.yb = RW'(box_center_y) - RW'({1'b0, box_half_h}) - RW'(ray_start_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1 <= ray_angle;
		geo_s1 <= geo_c;
	end

	// direction
	logic                    cd_v;
	logic signed [DIR_W-1:0] dx, dy;
	logic [TAG_W-1:0]        cd_tag;
	geo_t                    geo_d;

	rbnh_cordic #(
		.STEPS (CORDIC_STEPS),
		.TAG_W (TAG_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.angle     (ang_s1),
		.tag_in    (geo_s1),
		.out_valid (cd_v),
		.dir_x     (dx),
		.dir_y     (dy),
		.tag_out   (cd_tag)
	);

	assign geo_d = geo_t'(cd_tag);

	// edge lanes: right, top, left, bottom
	logic                   lane_v  [4];
	logic [DIST_W-1:0]      lane_d  [4];
	logic signed [PT_W-1:0] lane_px [4];
	logic signed [PT_W-1:0] lane_py [4];

	rbnh_edge #(.COORD_WIDTH(W)) u_edge_r (
		.clk(clk), .arst_n(arst_n), .in_valid(cd_v),
		.rel(geo_d.xr), .lo(geo_d.yb), .hi(geo_d.yt),
		.along(dx), .across(dy), .swap(1'b0),
		.org_x(geo_d.px), .org_y(geo_d.py),
		.out_valid(lane_v[0]), .dist_sq(lane_d[0]), .pt_x(lane_px[0]), .pt_y(lane_py[0])
	);

	rbnh_edge #(.COORD_WIDTH(W)) u_edge_t (
		.clk(clk), .arst_n(arst_n), .in_valid(cd_v),
		.rel(geo_d.yt), .lo(geo_d.xl), .hi(geo_d.xr),
		.along(dy), .across(dx), .swap(1'b1),
		.org_x(geo_d.px), .org_y(geo_d.py),
		.out_valid(lane_v[1]), .dist_sq(lane_d[1]), .pt_x(lane_px[1]), .pt_y(lane_py[1])
	);

	rbnh_edge #(.COORD_WIDTH(W)) u_edge_l (
		.clk(clk), .arst_n(arst_n), .in_valid(cd_v),
		.rel(geo_d.xl), .lo(geo_d.yb), .hi(geo_d.yt),
		.along(dx), .across(dy), .swap(1'b0),
		.org_x(geo_d.px), .org_y(geo_d.py),
		.out_valid(lane_v[2]), .dist_sq(lane_d[2]), .pt_x(lane_px[2]), .pt_y(lane_py[2])
	);

	rbnh_edge #(.COORD_WIDTH(W)) u_edge_b (
		.clk(clk), .arst_n(arst_n), .in_valid(cd_v),
		.rel(geo_d.yb), .lo(geo_d.xl), .hi(geo_d.xr),
		.along(dy), .across(dx), .swap(1'b1),
		.org_x(geo_d.px), .org_y(geo_d.py),
		.out_valid(lane_v[3]), .dist_sq(lane_d[3]), .pt_x(lane_px[3]), .pt_y(lane_py[3])
	);

	// stage 2: pairwise nearest, earlier edge wins ties
	logic                   v_s2;
	logic [DIST_W-1:0]      d_s2  [2];
	logic signed [PT_W-1:0] px_s2 [2];
	logic signed [PT_W-1:0] py_s2 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= lane_v[0];
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_pair
		logic sel;
		assign sel = lane_d[2*g+1] < lane_d[2*g];

		always_ff @(posedge clk) begin
			d_s2[g]  <= sel ? lane_d[2*g+1]  : lane_d[2*g];
			px_s2[g] <= sel ? lane_px[2*g+1] : lane_px[2*g];
			py_s2[g] <= sel ? lane_py[2*g+1] : lane_py[2*g];
		end
	end

	// stage 3: overall nearest against the limit
	logic                   v_s3, hit_s3;
	logic signed [PT_W-1:0] px_s3, py_s3;
	logic                   sel_f;
	logic [DIST_W-1:0]      d_f;

	assign sel_f = d_s2[1] < d_s2[0];
	assign d_f   = sel_f ? d_s2[1] : d_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		hit_s3 <= d_f < {1'b0, lim_q};
		px_s3  <= sel_f ? px_s2[1] : px_s2[0];
		py_s3  <= sel_f ? py_s2[1] : py_s2[0];
	end

	// result beat
	logic                done_q, hit_q;
	logic signed [W-1:0] hit_x_q, hit_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= v_s3;
			hit_q  <= v_s3 && hit_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_x_q <= hit_s3 ? clamp_coord(px_s3) : '0;
		hit_y_q <= hit_s3 ? clamp_coord(py_s3) : '0;
	end

	assign done  = done_q;
	assign hit   = hit_q;
	assign hit_x = hit_x_q;
	assign hit_y = hit_y_q;

	// checks
	`RBNH_ASSERT(a_latency, clk, arst_n, done == $past(accept, TOP_LAT))
	`RBNH_ASSERT_IMP(a_lanes_lockstep, clk, arst_n, lane_v[0], lane_v[1] && lane_v[2] && lane_v[3])
	`RBNH_ASSERT_IMP(a_hit_in_beat, clk, arst_n, hit, done)
	`RBNH_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !hit, hit_x == '0 && hit_y == '0)

endmodule

[test/ray_box_nearest_hit_checker.sv]
`timescale 1ns / 1ps

module ray_box_nearest_hit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic signed [31:0]          ray_start_x,
	input  logic signed [31:0]          ray_start_y,
	input  logic [rbnh_pkg::ANGLE_W-1:0] ray_angle,
	input  logic signed [31:0]          box_center_x,
	input  logic signed [31:0]          box_center_y,
	input  logic [30:0]                 box_half_w,
	input  logic [30:0]                 box_half_h,
	input  logic                        cfg_we,
	input  logic [rbnh_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                        done,
	input  logic                        hit,
	input  logic signed [31:0]          hit_x,
	input  logic signed [31:0]          hit_y,
	output int                          fail_count,
	output int                          pending
);

	typedef struct packed {
		logic               hit;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} hit_t;

	localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	hit_t                       hits_due[$];
	logic [rbnh_pkg::LIMIT_W-1:0] dist_limit;

	// angle to Q1.15 cosine/sine via 16-step CORDIC
	function automatic longint round15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32767) r = -32767;
		return r;
	endfunction

	function automatic void unit_dir(input logic [15:0] ang, output longint c, output longint s);
		logic [1:0] q;
		longint z, x, y, nx, cc, ss;
		q = ang[15:14];
		z = longint'(ang[13:0]) << 16;
		x = 652032874;
		y = 0;
		if (z >= (longint'(1) << 29)) begin
			z -= longint'(1) << 30;
			q = q + 2'd1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(rbnh_pkg::ATAN_TURNS[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(rbnh_pkg::ATAN_TURNS[i]);
			end
			x = nx;
		end
		cc = round15(x);
		ss = round15(y);
		case (q)
			2'd0: begin c = cc;  s = ss;  end
			2'd1: begin c = -ss; s = cc;  end
			2'd2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endfunction

	function automatic longint unsigned mag(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// signed-magnitude less-than
	function automatic bit sm_less(input bit an, input longint unsigned am,
			input bit bn, input longint unsigned bm);
		if (an != bn) return an;
		return an ? (am > bm) : (am < bm);
	endfunction

	// exact crossing test against one edge; off is the truncated offset along it
	function automatic bit cross_edge(input longint rel, input longint along,
			input longint across, input longint lo, input longint hi, output longint off);
		bit pn, ln, hn;
		longint unsigned pm, lm, hm, ad, q;
		off = 0;
		if (along == 0 || rel == 0 || ((rel < 0) != (along < 0))) return 0;
		ad = mag(along);
		pm = mag(rel) * mag(across);
		pn = (pm != 0) && ((rel < 0) != (across < 0));
		if (along < 0 && pm != 0) pn = !pn;
		lm = mag(lo) * ad;
		ln = (lm != 0) && (lo < 0);
		hm = mag(hi) * ad;
		hn = (hm != 0) && (hi < 0);
		if (!sm_less(ln, lm, pn, pm) || !sm_less(pn, pm, hn, hm)) return 0;
		q = pm / ad;
		off = pn ? -longint'(q) : longint'(q);
		return 1;
	endfunction

	function automatic longint unsigned square_sat(input longint v);
		longint unsigned m;
		m = mag(v);
		if (m >= (64'd1 << 32)) return ALL_ONES;
		return m * m;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic hit_t nearest_hit(input longint px, input longint py, input logic [15:0] ang,
			input longint cx, input longint cy, input longint hw, input longint hh,
			input longint unsigned limit);
		hit_t r;
		longint dx, dy, off, ox, oy, rel;
		longint unsigned best, d, d2;
		bit ok;
		r = '0;
		best = limit;
		unit_dir(ang, dx, dy);
		// right, top, left, bottom; strict compare keeps the earlier edge on ties
		for (int e = 0; e < 4; e++) begin
			if (e == 0 || e == 2) begin
				rel = (e == 0 ? cx + hw : cx - hw) - px;
				ok = cross_edge(rel, dx, dy, cy - hh - py, cy + hh - py, off);
				ox = rel;
				oy = off;
			end else begin
				rel = (e == 1 ? cy + hh : cy - hh) - py;
				ok = cross_edge(rel, dy, dx, cx - hw - px, cx + hw - px, off);
				ox = off;
				oy = rel;
			end
			if (ok) begin
				d = square_sat(ox);
				if (d != ALL_ONES) begin
					d2 = square_sat(oy);
					d = (d2 == ALL_ONES || d + d2 < d) ? ALL_ONES : d + d2;
				end
				if (d < best) begin
					best = d;
					r.hit = 1'b1;
					r.x = clamp32(px + ox);
					r.y = clamp32(py + oy);
				end
			end
		end
		return r;
	endfunction

	assign pending = hits_due.size();

	always @(posedge clk or negedge arst_n) begin
		hit_t want;
		if (!arst_n) begin
			dist_limit <= rbnh_pkg::reset_limit(16);
			hits_due.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we)
				dist_limit <= cfg_wdata;
			// compare a finished beat against the oldest prediction
			if (done) begin
				if (hits_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with nothing outstanding: hit=%0b x=%0d y=%0d",
							$realtime, hit, hit_x, hit_y);
					fail_count <= fail_count + 1;
				end else begin
					want = hits_due.pop_front();
					if (hit !== want.hit || hit_x !== want.x || hit_y !== want.y) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
								$realtime, want.hit, want.x, want.y, hit, hit_x, hit_y);
						fail_count <= fail_count + 1;
					end
				end
			end
			// predict each accepted beat
			if (start && !busy)
				hits_due.push_back(nearest_hit(longint'(ray_start_x), longint'(ray_start_y),
					ray_angle, longint'(box_center_x), longint'(box_center_y),
					longint'({33'd0, box_half_w}), longint'({33'd0, box_half_h}),
					{1'b0, dist_limit}));
		end
	end

endmodule

[test/ray_box_nearest_hit_top_tb.sv]
`timescale 1ns / 1ps

module ray_box_nearest_hit_top_tb;

	localparam int DRAIN_CYCLES = 60;
	localparam int STALL_LIMIT  = 2000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic signed [31:0]           ray_start_x = '0;
	logic signed [31:0]           ray_start_y = '0;
	logic [rbnh_pkg::ANGLE_W-1:0] ray_angle = '0;
	logic signed [31:0]           box_center_x = '0;
	logic signed [31:0]           box_center_y = '0;
	logic [30:0]                  box_half_w = '0;
	logic [30:0]                  box_half_h = '0;
	logic                         cfg_we = 1'b0;
	logic [rbnh_pkg::LIMIT_W-1:0] cfg_wdata = '0;
	logic                         done;
	logic                         hit;
	logic signed [31:0]           hit_x;
	logic signed [31:0]           hit_y;
	int                           fail_count;
	int                           pending;
	int                           idle_cycles = 0;
	bit                           burst_mode = 0;

	always #5 clk = ~clk;

	ray_box_nearest_hit_top i_dut (
		.clk, .arst_n, .start, .busy,
		.ray_start_x, .ray_start_y, .ray_angle,
		.box_center_x, .box_center_y, .box_half_w, .box_half_h,
		.cfg_we, .cfg_wdata,
		.done, .hit, .hit_x, .hit_y
	);

	ray_box_nearest_hit_checker i_checker (
		.clk, .arst_n, .start, .busy,
		.ray_start_x, .ray_start_y, .ray_angle,
		.box_center_x, .box_center_y, .box_half_w, .box_half_h,
		.cfg_we, .cfg_wdata,
		.done, .hit, .hit_x, .hit_y,
		.fail_count, .pending
	);

	// watchdog on cycles with no beat moving either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// present one query and hold it until taken, then maybe pause
	task automatic send_query(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic [15:0] ang, input logic signed [31:0] cx, input logic signed [31:0] cy,
			input logic [30:0] hw, input logic [30:0] hh);
		bit taken;
		int gap;
		start <= 1'b1;
		ray_start_x <= px;
		ray_start_y <= py;
		ray_angle <= ang;
		box_center_x <= cx;
		box_center_y <= cy;
		box_half_w <= hw;
		box_half_h <= hh;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		gap = burst_mode ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [62:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// box placed near the ray start so edges are likely to be crossed
	task automatic send_near();
		logic signed [31:0] px, py, cx, cy;
		logic [30:0] hw, hh;
		int span;
		span = ($urandom_range(0, 9) == 0) ? 32'h3FFF_FFFF : 32'h00FF_FFFF;
		px = $urandom;
		if ($urandom_range(0, 3) != 0) px = $signed(px) >>> $urandom_range(4, 12);
		py = $urandom;
		if ($urandom_range(0, 3) != 0) py = $signed(py) >>> $urandom_range(4, 12);
		cx = px + $signed($urandom_range(0, 2 * span) - span);
		cy = py + $signed($urandom_range(0, 2 * span) - span);
		hw = 31'($urandom_range(0, span));
		hh = 31'($urandom_range(0, span));
		if ($urandom_range(0, 15) == 0) hw = '0;
		send_query(px, py, 16'($urandom_range(0, 65535)), cx, cy, hw, hh);
	endtask

	initial begin
		logic [62:0] limits [4];
		limits = '{63'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd1 << 40, 63'd1 << 52};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axis angles, corner diagonals, degenerate boxes, extremes
		send_query(0, 0, 16'd0, 32'sd655360, 0, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd16384, 0, 32'sd655360, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd32768, -32'sd655360, 0, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd49152, 0, -32'sd655360, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd8192, 32'sd655360, 32'sd655360, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd8192, 32'sd720896, 32'sd589824, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd0, 32'sd65536, 0, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd100, 0, 0, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd0, 32'sd655360, 0, 31'd0, 31'd65536);
		send_query(0, 0, 16'd0, 32'sd655360, 0, 31'd0, 31'd0);
		send_query(0, 0, 16'd0, 32'sd655360, 32'sd65536, 31'd65536, 31'd65536);
		send_query(32'sh8000_0000, 32'sh8000_0000, 16'd8192, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd40960, 32'sh8000_0000, 32'sh8000_0000,
			31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_query(32'sh7FFF_FFFF, 0, 16'd0, 32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF, 31'd65536);
		send_query(0, 0, 16'd65535, 32'sh4000_0000, 0, 31'd65536, 31'h7FFF_FFFF);
		send_query(0, 0, 16'd24576, -32'sd655360, 32'sd655360, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd57344, 32'sd655360, -32'sd655360, 31'd65536, 31'd65536);
		send_query(0, 0, 16'd0, 32'sd2147483, 0, 31'd1, 31'd1);
		send_query(32'sd1, -32'sd1, 16'd12345, 32'sd1000, 32'sd2000, 31'd500, 31'd700);

		// random phases under several distance limits, ending on the default
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			if (ph < 4) write_limit(limits[ph]);
			else write_limit(rbnh_pkg::reset_limit(16));
			for (int n = 0; n < 340; n++) begin
				if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) != 0)
					send_near();
				else
					send_query($urandom, $urandom, 16'($urandom_range(0, 65535)),
						$urandom, $urandom, 31'($urandom), 31'($urandom));
			end
		end

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/rbnh_pkg.sv
src/rbnh_cordic.sv
src/rbnh_edge.sv
src/ray_box_nearest_hit_top.sv
test/ray_box_nearest_hit_checker.sv
test/ray_box_nearest_hit_top_tb.sv
